[rtl/t2mi_pkg.sv]
package t2mi_pkg;

  // Fixed T2-MI framing: header bytes, then payload, then CRC bytes.
  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned CRC_BYTES    = 4;

  localparam int unsigned PID_W   = 13;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CC_W    = 4;
  localparam int unsigned INDEX_W = 14;

  localparam logic [PID_W-1:0] PID_RESET = 13'h1FFF;

  // Header positions that carry the big-endian payload bit length.
  localparam logic [INDEX_W-1:0] LEN_HI_INDEX = 14'd4;
  localparam logic [INDEX_W-1:0] LEN_LO_INDEX = 14'd5;

  // One transport payload byte together with its packet header fields.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_packet;
    logic [BYTE_W-1:0] payload_len;
    logic [PID_W-1:0]  stream_pid;
    logic [CC_W-1:0]   cont_counter;
    logic              unit_start;
    logic              discontinuity;
    logic              scrambled;
  } item_t;

  // Stream tracking state kept between bytes.
  typedef struct packed {
    logic               in_sync;
    logic [CC_W-1:0]    last_cc;
    logic [BYTE_W-1:0]  skip_left;
    logic               pending_pointer;
    logic [INDEX_W-1:0] byte_index;
    logic [BYTE_W-1:0]  length_hi;
    logic [INDEX_W-1:0] packet_total;
  } state_t;

  // One extracted byte or an abort mark.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic              abort;
  } result_t;

  // Sync loss: the partial packet and any pointer skip are forgotten.
  function automatic state_t drop_sync(input state_t s);
    state_t r;
    r                 = s;
    r.in_sync         = 1'b0;
    r.skip_left       = '0;
    r.pending_pointer = 1'b0;
    r.byte_index      = '0;
    r.length_hi       = '0;
    r.packet_total    = '0;
    return r;
  endfunction

endpackage

[rtl/t2mi_step.sv]
module t2mi_step (
  input  logic [t2mi_pkg::PID_W-1:0] target_pid,
  input  t2mi_pkg::item_t            item,
  input  t2mi_pkg::state_t           state,
  output t2mi_pkg::state_t           state_nxt,
  output logic                       res_valid,
  output t2mi_pkg::result_t          res
);

  logic                              match;
  logic                              pkt_start;
  logic                              go_on;
  logic                              aborted;
  logic [t2mi_pkg::BYTE_W-1:0]       pf;
  logic [t2mi_pkg::CC_W-1:0]         cc_expect;
  logic [16:0]                       len_round;
  logic [t2mi_pkg::INDEX_W-1:0]      new_total;
  logic [t2mi_pkg::INDEX_W-1:0]      total_eff;
  logic [t2mi_pkg::INDEX_W:0]        idx_inc;
  t2mi_pkg::state_t                  s;

  assign match     = (item.stream_pid == target_pid) && !item.scrambled;
  assign pkt_start = item.first_of_packet || (item.payload_len == '0);
  assign pf        = (item.payload_len == '0) ? '0 : item.data_byte;
  assign cc_expect = state.last_cc + 4'd1;

  // Payload byte count from the bit length, rounded up, plus header and CRC.
  assign len_round = ({1'b0, state.length_hi, item.data_byte} + 17'd7) >> 3;
  assign new_total = 14'(len_round) + 14'(t2mi_pkg::HEADER_BYTES)
                   + 14'(t2mi_pkg::CRC_BYTES);
  assign idx_inc   = {1'b0, state.byte_index} + 15'd1;

  always_comb begin
    s         = state;
    go_on     = 1'b0;
    aborted   = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    total_eff = state.packet_total;

    if (match) begin
      go_on = 1'b1;

      // Transport packet boundary: continuity check and pointer field.
      if (pkt_start) begin
        s.skip_left       = '0;
        s.pending_pointer = 1'b0;
        if (s.in_sync && (item.discontinuity || (item.cont_counter != cc_expect))) begin
          aborted = (s.byte_index != '0);
          s       = t2mi_pkg::drop_sync(s);
        end
        s.last_cc = item.cont_counter;
        if (item.unit_start) begin
          go_on = 1'b0;
          if (({1'b0, pf} + 9'd1) >= {1'b0, item.payload_len}) begin
            // Pointer reaches past the payload: the whole packet is dropped.
            if (s.in_sync) begin
              aborted = (s.byte_index != '0);
              s       = t2mi_pkg::drop_sync(s);
            end
          end else if (!s.in_sync) begin
            s.in_sync         = 1'b1;
            s.skip_left       = pf;
            s.pending_pointer = (pf != '0);
          end
        end else if (aborted || (item.payload_len == '0)) begin
          go_on = 1'b0;
        end
      end

      if (aborted) begin
        res_valid = 1'b1;
        res.abort = 1'b1;
      end else if (go_on && s.in_sync) begin
        if (s.pending_pointer) begin
          // Skip the bytes that the pointer jumps over after resync.
          s.skip_left = s.skip_left - 8'd1;
          if (s.skip_left == '0) begin
            s.pending_pointer = 1'b0;
          end
        end else begin
          res_valid = 1'b1;
          res.data  = item.data_byte;
          res.first = (s.byte_index == '0);
          if (s.byte_index == t2mi_pkg::LEN_HI_INDEX) begin
            s.length_hi = item.data_byte;
          end else if (s.byte_index == t2mi_pkg::LEN_LO_INDEX) begin
            s.packet_total = new_total;
            total_eff      = new_total;
          end
          if ((s.byte_index >= t2mi_pkg::LEN_LO_INDEX) &&
              (idx_inc >= {1'b0, total_eff})) begin
            res.last       = 1'b1;
            s.byte_index   = '0;
            s.length_hi    = '0;
            s.packet_total = '0;
          end else begin
            s.byte_index = idx_inc[t2mi_pkg::INDEX_W-1:0];
          end
        end
      end
    end

    state_nxt = s;
  end

endmodule

[rtl/t2mi_packet_deframer.sv]
// T2-MI packet deframer.
// The input channel takes one transport payload byte per transfer, with the
// header fields of its transport packet on every byte. Bytes of the PID set
// in the configuration register are cut into T2-MI packets; other PIDs and
// scrambled packets are dropped silently.
// The result channel gives one T2-MI byte per transfer, marked with
// out_packet_start and out_packet_end, or an out_abort mark (out_byte zero)
// when sync is lost in the middle of a T2-MI packet.
// The configuration channel writes target_pid and clears the stream state;
// write it only while the block is idle. cfg_ready is always high.
// Each input transfer passes through one input register and one result
// register. Throughput is one byte per clock while the receiver does not
// stall, set by the combinational step logic between those two registers.
// When the receiver stalls, the result register holds and the input register
// fills; input is refused only when both are full.
// Synchronous reset sets target_pid to 8191, clears sync and the partial
// packet, and empties both registers.
module t2mi_packet_deframer (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [t2mi_pkg::PID_W-1:0]         cfg_data,
  // Input byte channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [t2mi_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                               in_first_of_packet,
  input  logic [t2mi_pkg::BYTE_W-1:0]        in_payload_len,
  input  logic [t2mi_pkg::PID_W-1:0]         in_stream_pid,
  input  logic [t2mi_pkg::CC_W-1:0]          in_cont_counter,
  input  logic                               in_unit_start,
  input  logic                               in_discontinuity,
  input  logic                               in_scrambled,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [t2mi_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_packet_start,
  output logic                               out_packet_end,
  output logic                               out_abort
);

  logic [t2mi_pkg::PID_W-1:0] target_pid_r;
  t2mi_pkg::state_t           state_r;
  t2mi_pkg::state_t           state_nxt;
  t2mi_pkg::item_t            item_r;
  t2mi_pkg::item_t            item_nxt;
  logic                       item_valid_r;
  t2mi_pkg::result_t          result_r;
  t2mi_pkg::result_t          step_res;
  logic                       step_valid;
  logic                       out_valid_r;
  logic                       advance;

  // The result register can take a new value when empty or being drained.
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !item_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign item_nxt = '{
    data_byte:       in_data_byte,
    first_of_packet: in_first_of_packet,
    payload_len:     in_payload_len,
    stream_pid:      in_stream_pid,
    cont_counter:    in_cont_counter,
    unit_start:      in_unit_start,
    discontinuity:   in_discontinuity,
    scrambled:       in_scrambled
  };

  t2mi_step u_step (
    .target_pid (target_pid_r),
    .item       (item_r),
    .state      (state_r),
    .state_nxt  (state_nxt),
    .res_valid  (step_valid),
    .res        (step_res)
  );

  // Control state: register, stream state and stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_pid_r <= t2mi_pkg::PID_RESET;
      state_r      <= '0;
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        target_pid_r <= cfg_data;
        state_r      <= '0;
      end else if (advance && item_valid_r) begin
        state_r <= state_nxt;
      end
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= item_valid_r && step_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
    if (advance) begin
      result_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = result_r.data;
  assign out_packet_start = result_r.first;
  assign out_packet_end   = result_r.last;
  assign out_abort        = result_r.abort;

  // A partial packet exists only while in sync.
  a_index_needs_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.byte_index != '0) |-> state_r.in_sync)
    else $error("byte index nonzero while out of sync");

  // A pending pointer skip always has bytes left and sync held.
  a_skip_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pending_pointer |-> (state_r.in_sync && (state_r.skip_left != '0)))
    else $error("pointer skip pending with nothing to skip");

  // The packet length is known only once the whole header has passed.
  a_total_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.packet_total != '0) |->
      (state_r.byte_index > t2mi_pkg::LEN_LO_INDEX))
    else $error("packet length set before header complete");

  // An abort result carries no byte and no packet marks.
  a_abort_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && result_r.abort) |->
      ((result_r.data == '0) && !result_r.first && !result_r.last))
    else $error("abort result carries data");

endmodule
